[hw/rtl/gsof_pkg.sv]
// shared types and constants for the guide sensor offset fork unit
package gsof_pkg;

  localparam int MAX_BITS = 16;
  localparam int IDX_W    = $clog2(MAX_BITS);
  localparam int CNT_W    = $clog2(MAX_BITS + 1);
  localparam int POS_W    = CNT_W + 1;
  localparam int RUNS_W   = 4;
  localparam int MODE_W   = 2;
  localparam int OFF_W    = 6;
  localparam int CFG_W    = 5;
  localparam int CFG_IDX_W = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SENSOR_WIDTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_WIDTH = 1'd1;

  localparam logic [CFG_W-1:0] SENSOR_WIDTH_RST = 5'd16;
  localparam logic [CFG_W-1:0] NORMAL_WIDTH_RST = 5'd4;

  // fork modes
  localparam logic [MODE_W-1:0] MODE_STRAIGHT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LEFT     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RIGHT    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_INVALID  = 2'd3;

  // counts gathered by one scan pass
  typedef struct packed {
    logic [CNT_W-1:0]  cnt;
    logic [CNT_W-1:0]  nr;
    logic [CNT_W-1:0]  nl;
    logic [RUNS_W-1:0] runs;
    logic [CNT_W-1:0]  first_len;
    logic [CNT_W-1:0]  last_len;
  } gsof_stats_t;

endpackage

[hw/rtl/gsof_if.sv]
// request and result channel interfaces
interface gsof_in_if
  import gsof_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [MAX_BITS-1:0] sensor_bits;
  logic [MODE_W-1:0] mode;

  modport source (output valid, sensor_bits, mode, input ready);
  modport sink   (input valid, sensor_bits, mode, output ready);
endinterface

interface gsof_out_if
  import gsof_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic signed [OFF_W-1:0] offset;
  logic                    error;
  logic [CNT_W-1:0]        active_count;
  logic [RUNS_W-1:0]       gap_runs;

  modport source (output valid, offset, error, active_count, gap_runs, input ready);
  modport sink   (input valid, offset, error, active_count, gap_runs, output ready);
endinterface

[hw/rtl/gsof_scan.sv]
// bit-serial scan unit: counts active bits, edge blanks, gap runs and first/last run lengths
module gsof_scan
  import gsof_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [MAX_BITS-1:0] vec,
  input  logic [CNT_W-1:0]    width,
  output logic                done,
  output gsof_stats_t         stats
);

  logic             busy;
  logic [IDX_W-1:0] idx;
  logic             seen;
  logic             in_first;
  logic [CNT_W-1:0] pending;
  logic [CNT_W-1:0] cur_ones;

  gsof_stats_t      stats_next;
  logic             seen_next;
  logic             in_first_next;
  logic [CNT_W-1:0] pending_next;
  logic [CNT_W-1:0] cur_ones_next;
  logic [CNT_W-1:0] width_m1;
  logic             last;
  logic             bit_b;

  assign bit_b    = vec[idx];
  assign width_m1 = width - CNT_W'(1);
  assign last     = busy && ({1'b0, idx} == width_m1);

  always_comb begin
    stats_next    = stats;
    seen_next     = seen;
    in_first_next = in_first;
    pending_next  = pending;
    cur_ones_next = cur_ones;
    if (bit_b) begin
      stats_next.cnt = stats.cnt + CNT_W'(1);
      if (!seen) begin
        seen_next            = 1'b1;
        in_first_next        = 1'b1;
        stats_next.first_len = CNT_W'(1);
      end else begin
        if (in_first) stats_next.first_len = stats.first_len + CNT_W'(1);
        if (pending != '0) stats_next.runs = stats.runs + RUNS_W'(1);
      end
      pending_next        = '0;
      cur_ones_next       = cur_ones + CNT_W'(1);
      stats_next.last_len = cur_ones + CNT_W'(1);
    end else begin
      cur_ones_next = '0;
      if (!seen) begin
        stats_next.nr = stats.nr + CNT_W'(1);
      end else begin
        pending_next  = pending + CNT_W'(1);
        in_first_next = 1'b0;
      end
    end
    stats_next.nl = seen_next ? pending_next : width;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      idx  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        idx      <= '0;
        seen     <= 1'b0;
        in_first <= 1'b0;
        pending  <= '0;
        cur_ones <= '0;
        stats    <= '0;
      end else if (busy) begin
        seen     <= seen_next;
        in_first <= in_first_next;
        pending  <= pending_next;
        cur_ones <= cur_ones_next;
        stats    <= stats_next;
        idx      <= idx + IDX_W'(1);
        if (last) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[hw/rtl/guide_sensor_offset_fork_unit.sv]
// top level: sequencer around the shared scan unit, config registers, result register
//
//  channel   dir  handshake       payload
//  sensor    in   valid / ready   sensor_bits[15:0], mode[1:0]
//  result    out  valid / ready   offset[5:0] signed, error, active_count[4:0], gap_runs[3:0]
//  config    in   cfg_we          cfg_index[0], cfg_data[4:0]
//
// one request runs P scan passes, w the clamped sensor width and P from 1 to w + 1;
// each pass is a start state, a bit-serial sweep of the scan unit (one bit a cycle),
// the wait for its done flag, a decide state and an edit or finish state; before the
// first pass the request is accepted in the idle state, and a plain track with no
// cleanup needs a single pass
// synchronous active-high reset returns the sequencer to idle, drops result valid
// and loads sensor_width 16 and normal_width 4
// sensor ready is high only while the sequencer is idle; a finished result sits in
// the output register, so a new request is taken while the old result waits
module guide_sensor_offset_fork_unit
  import gsof_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  gsof_in_if.sink              sensor,
  gsof_out_if.source           result
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_SCAN,
    ST_DECIDE,
    ST_EDIT,
    ST_FINISH
  } state_t;

  state_t state;

  // configuration registers
  logic [CFG_W-1:0] sensor_width;
  logic [CFG_W-1:0] normal_width;

  always_ff @(posedge clk) begin
    if (rst) begin
      sensor_width <= SENSOR_WIDTH_RST;
      normal_width <= NORMAL_WIDTH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SENSOR_WIDTH: sensor_width <= cfg_data;
        REG_NORMAL_WIDTH: normal_width <= cfg_data;
        default: ;
      endcase
    end
  end

  // working copy of the request
  logic [MAX_BITS-1:0] vec;
  logic [CNT_W-1:0]    w;
  logic [MODE_W-1:0]   mode;

  // width clamped to 1..MAX_BITS
  logic [CNT_W-1:0]    w_eff;
  logic [MAX_BITS-1:0] vec_in;

  always_comb begin
    if (sensor_width == '0) begin
      w_eff = CNT_W'(1);
    end else if (sensor_width > CFG_W'(MAX_BITS)) begin
      w_eff = CNT_W'(MAX_BITS);
    end else begin
      w_eff = sensor_width[CNT_W-1:0];
    end
    for (int i = 0; i < MAX_BITS; i++) begin
      vec_in[i] = sensor.sensor_bits[i] && (CNT_W'(i) < w_eff);
    end
  end

  // shared scan unit
  logic        scan_start;
  logic        scan_done;
  gsof_stats_t stats;

  assign scan_start = (state == ST_START);

  gsof_scan u_scan (
    .clk   (clk),
    .rst   (rst),
    .start (scan_start),
    .vec   (vec),
    .width (w),
    .done  (scan_done),
    .stats (stats)
  );

  // pass decision: either finish with a result or clear the range [lo, end)
  logic                    dec_finish;
  logic signed [OFF_W-1:0] dec_off;
  logic                    dec_err;
  logic [POS_W-1:0]        dec_lo;
  logic [POS_W-1:0]        dec_end;
  logic                    left_sel;
  logic                    right_sel;
  logic [CNT_W-1:0]        excess;
  logic [POS_W-1:0]        left_end;

  always_comb begin
    left_sel  = (mode == MODE_RIGHT) || ((mode == MODE_STRAIGHT) && (stats.nl < stats.nr));
    right_sel = (mode == MODE_LEFT) || ((mode == MODE_STRAIGHT) && (stats.nl > stats.nr));
    excess    = stats.cnt - normal_width;
    left_end  = {1'b0, w} - {1'b0, stats.nl};
    dec_finish = 1'b1;
    dec_off    = '0;
    dec_err    = 1'b0;
    dec_lo     = '0;
    dec_end    = '0;
    if (stats.cnt == '0) begin
      // no track seen
      dec_err = 1'b1;
    end else if (stats.runs != '0) begin
      if (stats.runs == RUNS_W'(1)) begin
        if (left_sel) begin
          dec_finish = 1'b0;
          dec_end    = left_end;
          dec_lo     = left_end - {1'b0, stats.last_len};
        end else if (right_sel) begin
          dec_finish = 1'b0;
          dec_lo     = {1'b0, stats.nr};
          dec_end    = {1'b0, stats.nr} + {1'b0, stats.first_len};
        end else begin
          dec_err = (mode == MODE_INVALID);
        end
      end
    end else if (stats.cnt > normal_width) begin
      // a full-width run is a crossing and stays as it is
      if (stats.cnt != w) begin
        if (left_sel) begin
          dec_finish = 1'b0;
          dec_end    = left_end;
          dec_lo     = left_end - {1'b0, excess};
        end else if (right_sel) begin
          dec_finish = 1'b0;
          dec_lo     = {1'b0, stats.nr};
          dec_end    = {1'b0, stats.nr} + {1'b0, excess};
        end
      end
    end else begin
      dec_off = $signed({1'b0, stats.nl}) - $signed({1'b0, stats.nr});
    end
  end

  // range clear applied in the edit cycle
  logic [POS_W-1:0]    clr_lo;
  logic [POS_W-1:0]    clr_end;
  logic [MAX_BITS-1:0] vec_edit;

  always_comb begin
    for (int i = 0; i < MAX_BITS; i++) begin
      vec_edit[i] = vec[i] && !((POS_W'(i) >= clr_lo) && (POS_W'(i) < clr_end));
    end
  end

  // final pass values waiting for the output register
  logic signed [OFF_W-1:0] res_off;
  logic                    res_err;
  logic [CNT_W-1:0]        res_cnt;
  logic [RUNS_W-1:0]       res_runs;

  logic                    out_valid;
  logic                    out_load;
  logic signed [OFF_W-1:0] out_off;
  logic                    out_err;
  logic [CNT_W-1:0]        out_cnt;
  logic [RUNS_W-1:0]       out_runs;

  // output register takes the finished result once it is free or being drained
  assign out_load = (state == ST_FINISH) && (!out_valid || result.ready);

  assign sensor.ready        = (state == ST_IDLE);
  assign result.valid        = out_valid;
  assign result.offset       = out_off;
  assign result.error        = out_err;
  assign result.active_count = out_cnt;
  assign result.gap_runs     = out_runs;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (result.ready && !out_load) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (sensor.valid) begin
            vec   <= vec_in;
            w     <= w_eff;
            mode  <= sensor.mode;
            state <= ST_START;
          end
        end
        ST_START: begin
          state <= ST_SCAN;
        end
        ST_SCAN: begin
          if (scan_done) state <= ST_DECIDE;
        end
        ST_DECIDE: begin
          if (dec_finish) begin
            res_off  <= dec_off;
            res_err  <= dec_err;
            res_cnt  <= stats.cnt;
            res_runs <= stats.runs;
            state    <= ST_FINISH;
          end else begin
            clr_lo  <= dec_lo;
            clr_end <= dec_end;
            state   <= ST_EDIT;
          end
        end
        ST_EDIT: begin
          vec   <= vec_edit;
          state <= ST_START;
        end
        ST_FINISH: begin
          // wait for the output register to free up
          if (out_load) begin
            out_valid <= 1'b1;
            out_off   <= res_off;
            out_err   <= res_err;
            out_cnt   <= res_cnt;
            out_runs  <= res_runs;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// self-checking testbench for the guide sensor offset fork unit
module testbench;
  import gsof_pkg::*;

  // receiver hold-off long enough to back the sequencer up behind a waiting result
  localparam int HOLD_OFF_CYCLES = 400;
  // final settle wait, sized for the worst request at full width
  localparam int SCAN_LATENCY    = 345;
  // cycles with no handshake on either channel before the run is called hung
  localparam int STALL_LIMIT     = 4000;
  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 75;
  localparam int PROBE_ROWS      = 23;

  // one result as the block reports it
  typedef struct packed {
    logic signed [OFF_W-1:0] offset;
    logic                    error;
    logic [CNT_W-1:0]        active_count;
    logic [RUNS_W-1:0]       gap_runs;
  } track_fix_t;

  // directed request; known rows carry a hand-computed result
  typedef struct {
    logic [MAX_BITS-1:0] bits;
    logic [MODE_W-1:0]   mode;
    bit                  known;
    int                  offset;
    int                  error;
    int                  active_count;
    int                  gap_runs;
  } probe_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_SENSOR_WIDTH;
  logic [CFG_W-1:0]     cfg_data = '0;

  gsof_in_if  sensor_ch ();
  gsof_out_if result_ch ();

  // local copy of the two width registers, as last written
  logic [CFG_W-1:0] sensor_width_cfg = SENSOR_WIDTH_RST;
  logic [CFG_W-1:0] normal_width_cfg = NORMAL_WIDTH_RST;

  track_fix_t pending_fixes [$];
  int         src_idle_pct  = 29;
  int         sink_idle_pct = 53;
  bit         hold_off_req  = 1'b0;
  int         mismatches    = 0;
  int         results_seen  = 0;
  int         requests_sent = 0;
  int         stall_count   = 0;

  // register settings per random phase, extremes included
  int width_plan [NUM_PHASES][2] = '{
    '{16, 4}, '{1, 1}, '{0, 0}, '{31, 31}, '{16, 16}, '{8, 2}, '{5, 0}, '{16, 1}
  };

  // directed requests, all at the reset widths (16 bits, normal width 4)
  probe_row_t probe_table [PROBE_ROWS] = '{
    '{16'h0000, MODE_STRAIGHT, 1'b1,   0, 1,  0, 0},  // no track
    '{16'hFFFF, MODE_STRAIGHT, 1'b1,   0, 0, 16, 0},  // crossing, all bits active
    '{16'h0180, MODE_STRAIGHT, 1'b1,   0, 0,  2, 0},  // centered plain track
    '{16'h0001, MODE_STRAIGHT, 1'b1,  15, 0,  1, 0},  // track at the right end
    '{16'h8000, MODE_STRAIGHT, 1'b1, -15, 0,  1, 0},  // track at the left end
    '{16'h0F0F, MODE_INVALID,  1'b1,   0, 1,  8, 1},  // single gap, invalid mode
    '{16'h0C30, MODE_STRAIGHT, 1'b1,   0, 0,  4, 1},  // single gap, straight, even blanks
    '{16'h5555, MODE_LEFT,     1'b1,   0, 0,  8, 7},  // many gap runs, left alone
    '{16'h00FF, MODE_INVALID,  1'b1,   0, 0,  8, 0},  // too wide, invalid mode
    '{16'h0FF0, MODE_STRAIGHT, 1'b1,   0, 0,  8, 0},  // too wide, straight, even blanks
    '{16'h0000, MODE_INVALID,  1'b1,   0, 1,  0, 0},  // no track, invalid mode
    '{16'h0F0F, MODE_LEFT,     1'b0,   0, 0,  0, 0},
    '{16'h0F0F, MODE_RIGHT,    1'b0,   0, 0,  0, 0},
    '{16'h0F03, MODE_STRAIGHT, 1'b0,   0, 0,  0, 0},
    '{16'hF0C0, MODE_STRAIGHT, 1'b0,   0, 0,  0, 0},
    '{16'h00FF, MODE_LEFT,     1'b0,   0, 0,  0, 0},
    '{16'h00FF, MODE_RIGHT,    1'b0,   0, 0,  0, 0},
    '{16'hFF00, MODE_STRAIGHT, 1'b0,   0, 0,  0, 0},
    '{16'h03FF, MODE_STRAIGHT, 1'b0,   0, 0,  0, 0},
    '{16'hFFFE, MODE_RIGHT,    1'b0,   0, 0,  0, 0},
    '{16'hAAAA, MODE_STRAIGHT, 1'b0,   0, 0,  0, 0},
    '{16'h7FFE, MODE_LEFT,     1'b0,   0, 0,  0, 0},
    '{16'h6DB6, MODE_RIGHT,    1'b0,   0, 0,  0, 0}
  };

  guide_sensor_offset_fork_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sensor    (sensor_ch.sink),
    .result    (result_ch.source)
  );

  always #1 clk = ~clk;

  // sensor width as the block uses it: 0 reads as 1, above 16 reads as 16
  function automatic int clamped_width();
    int w;
    w = sensor_width_cfg;
    if (w < 1) w = 1;
    if (w > MAX_BITS) w = MAX_BITS;
    return w;
  endfunction

  // expected result of one request under the current widths
  function automatic track_fix_t track_fix_of(input logic [MAX_BITS-1:0] raw,
                                              input logic [MODE_W-1:0] md);
    logic [MAX_BITS-1:0] v;
    int w, nw, cnt, runs, nr, nl, zeros, off, err, k, i, j, pass;
    bit cut_left, cut_right;
    track_fix_t fix;
    w = clamped_width();
    nw = normal_width_cfg;
    v = raw;
    for (i = w; i < MAX_BITS; i++) v[i] = 1'b0;
    cnt = 0;
    runs = 0;
    off = 0;
    err = 0;
    // every repeated pass clears at least one bit
    for (pass = 0; pass < MAX_BITS + 2; pass++) begin
      cnt = 0;
      runs = 0;
      nr = 0;
      nl = 0;
      zeros = 0;
      off = 0;
      err = 0;
      for (i = 0; i < w; i++) cnt += v[i];
      while (nr < w && !v[nr]) nr++;
      while (nl < w && !v[w - 1 - nl]) nl++;
      if (cnt == 0) begin
        err = 1;
        break;
      end
      // interior zeros and the runs they form
      for (i = nr; i + nl < w; i++) begin
        if (!v[i]) begin
          zeros++;
          if (i == nr || v[i - 1]) runs++;
        end
      end
      cut_left  = (md == MODE_RIGHT) || (md == MODE_STRAIGHT && nl < nr);
      cut_right = (md == MODE_LEFT) || (md == MODE_STRAIGHT && nl > nr);
      if (zeros > 0) begin
        if (runs != 1) break;
        if (cut_left) begin
          for (j = nl; j < w && v[w - 1 - j]; j++) v[w - 1 - j] = 1'b0;
          continue;
        end
        if (cut_right) begin
          for (j = nr; j < w && v[j]; j++) v[j] = 1'b0;
          continue;
        end
        if (md == MODE_INVALID) err = 1;
        break;
      end
      if (cnt > nw) begin
        k = cnt - nw;
        if (cnt == w) break;
        if (cut_left) begin
          for (j = 0; j < k && nl + j < w; j++) v[w - 1 - nl - j] = 1'b0;
          continue;
        end
        if (cut_right) begin
          for (j = 0; j < k && nr + j < w; j++) v[nr + j] = 1'b0;
          continue;
        end
        break;
      end
      off = nl - nr;
      break;
    end
    fix.offset       = off[OFF_W-1:0];
    fix.error        = err[0];
    fix.active_count = cnt[CNT_W-1:0];
    fix.gap_runs     = runs[RUNS_W-1:0];
    return fix;
  endfunction

  // contiguous block of set bits, clipped at the top of the vector
  function automatic logic [MAX_BITS-1:0] track_span(input int lo, input int len);
    logic [MAX_BITS-1:0] v;
    int i;
    v = '0;
    for (i = lo; i < lo + len && i < MAX_BITS; i++) v[i] = 1'b1;
    return v;
  endfunction

  // mostly track-like vectors inside the active width, plus noise and junk above it
  function automatic logic [MAX_BITS-1:0] draw_track();
    logic [MAX_BITS-1:0] v, low_mask;
    int w, lo, len, gap, len2;
    w = clamped_width();
    low_mask = track_span(0, w);
    lo = $urandom_range(0, w - 1);
    len = $urandom_range(1, 4);
    gap = $urandom_range(1, 4);
    len2 = $urandom_range(1, 4);
    case ($urandom_range(0, 11))
      0, 1, 2, 3: begin
        len = $urandom_range(1, w);
        v = track_span($urandom_range(0, w - len), len);
      end
      4, 5, 6: v = track_span(lo, len) | track_span(lo + len + gap, len2);
      7: v = track_span(lo, len) | track_span(lo + len + gap, len2)
             | track_span(lo + len + gap + len2 + $urandom_range(1, 3), $urandom_range(1, 3));
      8: v = MAX_BITS'($urandom);
      9: v = $urandom_range(0, 1) ? '1 : '0;
      10: v = MAX_BITS'($urandom) & MAX_BITS'($urandom);
      default: begin
        // wide track hugging one end, the usual trim case
        len = $urandom_range((w + 1) / 2, w);
        v = $urandom_range(0, 1) ? track_span(0, len) : track_span(w - len, len);
      end
    endcase
    if ($urandom_range(0, 3) == 0) v |= MAX_BITS'($urandom) & ~low_mask;
    return v;
  endfunction

  function automatic logic [MODE_W-1:0] draw_mode();
    case ($urandom_range(0, 9))
      0, 1, 2: return MODE_STRAIGHT;
      3, 4, 5: return MODE_LEFT;
      6, 7, 8: return MODE_RIGHT;
      default: return MODE_INVALID;
    endcase
  endfunction

  // called and returns at a falling edge; records the expected result on acceptance
  task automatic send_request(input logic [MAX_BITS-1:0] bits, input logic [MODE_W-1:0] md,
                              input bit known, input track_fix_t golden);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      sensor_ch.valid <= 1'b0;
      @(negedge clk);
    end
    sensor_ch.valid       <= 1'b1;
    sensor_ch.sensor_bits <= bits;
    sensor_ch.mode        <= md;
    do begin
      @(posedge clk);
    end while (!sensor_ch.ready);
    pending_fixes.push_back(known ? golden : track_fix_of(bits, md));
    requests_sent++;
    @(negedge clk);
  endtask

  // stop offering and wait at falling edges until every result is back
  task automatic drain_results();
    sensor_ch.valid <= 1'b0;
    do begin
      @(negedge clk);
    end while (pending_fixes.size() != 0);
  endtask

  // both width registers, one write each, only while the block is idle
  task automatic apply_widths(input logic [CFG_W-1:0] sw, input logic [CFG_W-1:0] nw);
    cfg_we    <= 1'b1;
    cfg_index <= REG_SENSOR_WIDTH;
    cfg_data  <= sw;
    @(negedge clk);
    cfg_index <= REG_NORMAL_WIDTH;
    cfg_data  <= nw;
    @(negedge clk);
    cfg_we <= 1'b0;
    sensor_width_cfg = sw;
    normal_width_cfg = nw;
  endtask

  // main stimulus
  initial begin
    probe_row_t row;
    track_fix_t golden;
    int phase, n;
    sensor_ch.valid       = 1'b0;
    sensor_ch.sensor_bits = '0;
    sensor_ch.mode        = MODE_STRAIGHT;
    // reset asserted from the start, released at a falling edge
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part runs on the reset widths, nothing written yet
    foreach (probe_table[r]) begin
      row = probe_table[r];
      golden.offset       = row.offset[OFF_W-1:0];
      golden.error        = row.error[0];
      golden.active_count = row.active_count[CNT_W-1:0];
      golden.gap_runs     = row.gap_runs[RUNS_W-1:0];
      send_request(row.bits, row.mode, row.known, golden);
    end

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      drain_results();
      apply_widths(width_plan[phase][0][CFG_W-1:0], width_plan[phase][1][CFG_W-1:0]);
      // idle mix: sender light / receiver heavy, then swapped, then none
      if (phase < 3) begin
        src_idle_pct  = 29;
        sink_idle_pct = 53;
      end else if (phase < 6) begin
        src_idle_pct  = 53;
        sink_idle_pct = 29;
      end else begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        // long receiver hold-off while requests keep coming, so input ready drops
        if (phase == 0 && n == 20) hold_off_req = 1'b1;
        // sender pause until the pipeline is empty
        if (phase == 4 && n == 40) drain_results();
        golden = '0;
        send_request(draw_track(), draw_mode(), 1'b0, golden);
      end
    end

    drain_results();
    repeat (SCAN_LATENCY) @(negedge clk);
    if (pending_fixes.size() != 0) begin
      mismatches++;
      $display("%0t %0d results never arrived", $time, pending_fixes.size());
    end
    $display("run covered %0d requests (%0d directed) over %0d width settings",
             requests_sent, PROBE_ROWS, NUM_PHASES + 1);
    $display("%0d results compared, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  // result receiver: random ready, or a counted hold-off when asked
  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        result_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
      end else begin
        result_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
      end
    end
  end

  // compare each accepted result with the oldest pending expectation
  always @(posedge clk) begin : check_results
    track_fix_t seen;
    track_fix_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      seen = {result_ch.offset, result_ch.error, result_ch.active_count, result_ch.gap_runs};
      results_seen++;
      if (pending_fixes.size() == 0) begin
        mismatches++;
        $display("%0t result with no request pending: offset %0d error %0b count %0d runs %0d",
                 $time, seen.offset, seen.error, seen.active_count, seen.gap_runs);
      end else begin
        want = pending_fixes.pop_front();
        if (seen !== want) begin
          mismatches++;
          $display({"%0t mismatch: expected offset %0d error %0b count %0d runs %0d,",
                    " got %0d %0b %0d %0d"},
                   $time, want.offset, want.error, want.active_count, want.gap_runs,
                   seen.offset, seen.error, seen.active_count, seen.gap_runs);
        end
      end
    end
  end

  // watchdog on cycles with no handshake on either channel
  always @(posedge clk) begin
    if (rst || (sensor_ch.valid && sensor_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      stall_count <= 0;
    end else if (stall_count >= STALL_LIMIT) begin
      $display("%0t no handshake for %0d cycles", $time, STALL_LIMIT);
      $display("testbench: errors");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

endmodule
